FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is low.
`define SBLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define SBLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sblt_pkg.sv
// ----------------------------------------------------------------------------
// sblt_pkg
// Beat types, band table and state codes of the band level tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sblt_pkg;

  // Field widths of the beats
  localparam int BIN_W   = 10;
  localparam int MAG_W   = 40;
  localparam int BAND_W  = 4;
  localparam int LEVEL_W = 17;
  localparam int DECAY_W = 16;

  // Q0.16 scaling and product layout
  localparam int Q_FRAC     = 16;
  localparam int CUBE_SHIFT = 32;
  localparam int SQ_W       = 2 * LEVEL_W;
  localparam int CUBE_W     = 3 * LEVEL_W;
  localparam int DPROD_W    = LEVEL_W + DECAY_W;

  // Decay factor after reset, about 0.96 in Q0.16
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd62915;

  // Band edges, inclusive; unused slots are empty (low above high)
  localparam int MAX_BANDS = 16;
  localparam logic [BIN_W-1:0] BAND_LO [MAX_BANDS] = '{
    10'd1, 10'd4, 10'd6, 10'd10, 10'd17, 10'd30, 10'd55, 10'd99, 10'd181,
    10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1
  };
  localparam logic [BIN_W-1:0] BAND_HI [MAX_BANDS] = '{
    10'd3, 10'd5, 10'd9, 10'd16, 10'd29, 10'd54, 10'd98, 10'd180, 10'd512,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
  };

  // Input beat: one magnitude bin
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;
  } in_item_t;

  // Result beat: one held band level
  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } res_item_t;

  // Frame sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_MAX,
    ST_RD,
    ST_DIVGO,
    ST_DIV,
    ST_CUBE,
    ST_SHAPE,
    ST_UPD
  } sblt_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/spectrum_band_level_tracker_core.sv
// ----------------------------------------------------------------------------
// spectrum_band_level_tracker_core
// Per-band peak hold over magnitude bins with cubic shaping and level decay.
// ----------------------------------------------------------------------------
// While busy is low the core takes one bin beat per clock and folds it into
// the peak of its band in the peak memory (read, compare, write back, with a
// forward path for back-to-back bins of one band). A beat with frame_end
// raises busy for the fold state, a sweep of the peak memory for the largest
// peak, then a pass per band through the 17-step restoring divider, two
// multiplier stages and the read-modify-write of the held level memory.
// Results come out one band per pass, each with res_strobe_o high for a
// single cycle; the receiver cannot stall them and must take each beat as
// it comes.
// Both memories start as all zero after reset through per-entry valid bits,
// so no clearing pass is needed; the peaks are cleared the same way at the
// end of every frame.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_band_level_tracker_core
  import sblt_pkg::*;
#(
  parameter int NUM_BANDS = 9,
  parameter int BIN_COUNT = 1024,
  parameter int MAG_BITS  = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DECAY_W-1:0] cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item_i,
  output logic               res_strobe_o,
  output res_item_t          res_o
);

  localparam int PEAK_W = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
  localparam int IDX_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CNT_W  = $clog2(NUM_BANDS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BANDS - 1);
  localparam logic [CNT_W-1:0] NB_CNT   = CNT_W'(NUM_BANDS);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  sblt_state_e state_q, state_d;

  logic [DECAY_W-1:0] decay_q;

  logic             in_accept;
  logic             in_hit;
  logic [IDX_W-1:0] in_band;
  logic             in_range;

  logic              s1_vld_q;
  logic [IDX_W-1:0]  s1_band_q;
  logic [PEAK_W-1:0] s1_mag_q;

  logic [PEAK_W-1:0]    peak_mem [NUM_BANDS];
  logic [NUM_BANDS-1:0] peak_vld_q;
  logic [PEAK_W-1:0]    peak_rdata_q;
  logic                 peak_rvld_q;
  logic                 peak_re;
  logic [IDX_W-1:0]     peak_raddr;
  logic                 peak_we;
  logic [PEAK_W-1:0]    peak_wdata;
  logic                 peak_clr;
  logic [PEAK_W-1:0]    peak_old;
  logic [PEAK_W-1:0]    peak_cur;

  logic              fwd_vld_q;
  logic [IDX_W-1:0]  fwd_band_q;
  logic [PEAK_W-1:0] fwd_val_q;

  logic [LEVEL_W-1:0]   held_mem [NUM_BANDS];
  logic [NUM_BANDS-1:0] held_vld_q;
  logic [LEVEL_W-1:0]   held_rdata_q;
  logic                 held_rvld_q;
  logic                 held_re;
  logic                 held_we;
  logic [LEVEL_W-1:0]   held_cur;
  logic [LEVEL_W-1:0]   held_new;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  band_idx_q, band_idx_d;
  logic [PEAK_W-1:0] top_q, top_d;
  logic              band_last;

  logic               div_start;
  logic               div_done;
  logic [LEVEL_W-1:0] quo;

  logic [SQ_W-1:0]    sq_q;
  logic [CUBE_W-1:0]  cube_prod;
  logic [LEVEL_W-1:0] cube_q;
  logic [DPROD_W-1:0] decay_prod;

  logic      res_strobe_q;
  res_item_t res_q;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
    end else if (cfg_we_i) begin
      decay_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Band lookup of the incoming bin
  // --------------------------------------------------------------------------
  assign in_accept = start && !busy;
  assign in_range  = 32'(item_i.bin) < BIN_COUNT;

  always_comb begin
    in_hit  = 1'b0;
    in_band = '0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (in_range && (item_i.bin >= BAND_LO[b]) && (item_i.bin <= BAND_HI[b])) begin
        in_hit  = 1'b1;
        in_band = IDX_W'(b);
      end
    end
  end

  // Hold the bin beat while its peak is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_accept && in_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_band_q <= in_band;
      s1_mag_q  <= item_i.magnitude[PEAK_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Peak fold: forward the last write when the same band follows directly
  // --------------------------------------------------------------------------
  assign peak_cur = peak_rvld_q ? peak_rdata_q : '0;

  always_comb begin
    if (fwd_vld_q && (fwd_band_q == s1_band_q)) begin
      peak_old = fwd_val_q;
    end else begin
      peak_old = peak_cur;
    end
    peak_wdata = (s1_mag_q > peak_old) ? s1_mag_q : peak_old;
    peak_we    = s1_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= peak_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (peak_we) begin
      fwd_band_q <= s1_band_q;
      fwd_val_q  <= peak_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Peak memory with per-entry valid bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (peak_we) begin
      peak_mem[s1_band_q] <= peak_wdata;
    end
    if (peak_re) begin
      peak_rdata_q <= peak_mem[peak_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_vld_q  <= '0;
      peak_rvld_q <= 1'b0;
    end else begin
      if (peak_clr) begin
        peak_vld_q <= '0;
      end else if (peak_we) begin
        peak_vld_q[s1_band_q] <= 1'b1;
      end
      if (peak_re) begin
        peak_rvld_q <= peak_vld_q[peak_raddr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Held level memory with per-entry valid bits
  // --------------------------------------------------------------------------
  assign held_cur = held_rvld_q ? held_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_mem[band_idx_q] <= held_new;
    end
    if (held_re) begin
      held_rdata_q <= held_mem[band_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q  <= '0;
      held_rvld_q <= 1'b0;
    end else begin
      if (held_we) begin
        held_vld_q[band_idx_q] <= 1'b1;
      end
      if (held_re) begin
        held_rvld_q <= held_vld_q[band_idx_q];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame sequencer: next state
  // --------------------------------------------------------------------------
  assign band_last = band_idx_q == LAST_IDX;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && item_i.frame_end) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_d = ST_MAX;
      end
      ST_MAX: begin
        if (cnt_q == NB_CNT) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_DIVGO;
      end
      ST_DIVGO: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_CUBE;
        end
      end
      ST_CUBE: begin
        state_d = ST_SHAPE;
      end
      ST_SHAPE: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = band_last ? ST_IDLE : ST_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame sequencer: outputs and counters
  // --------------------------------------------------------------------------
  always_comb begin
    busy       = 1'b1;
    peak_re    = 1'b0;
    peak_raddr = band_idx_q;
    peak_clr   = 1'b0;
    held_re    = 1'b0;
    held_we    = 1'b0;
    div_start  = 1'b0;
    cnt_d      = cnt_q;
    band_idx_d = band_idx_q;
    top_d      = top_q;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        peak_re    = in_accept && in_hit;
        peak_raddr = in_band;
      end
      ST_FOLD: begin
        cnt_d = '0;
        top_d = PEAK_W'(1);
      end
      ST_MAX: begin
        // issue one read a cycle, compare the one that came back
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q != NB_CNT) begin
          peak_re    = 1'b1;
          peak_raddr = cnt_q[IDX_W-1:0];
        end
        if ((cnt_q != '0) && (peak_cur > top_q)) begin
          top_d = peak_cur;
        end
        band_idx_d = '0;
      end
      ST_RD: begin
        peak_re = 1'b1;
        held_re = 1'b1;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
      end
      ST_UPD: begin
        held_we    = 1'b1;
        peak_clr   = band_last;
        band_idx_d = band_idx_q + IDX_W'(1);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      band_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      band_idx_q <= band_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // --------------------------------------------------------------------------
  // Normalize: peak * 2^16 / top
  // --------------------------------------------------------------------------
  sblt_div #(
    .W (PEAK_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (peak_cur),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // --------------------------------------------------------------------------
  // Cube in two multiplier stages, then decay or take the new level
  // --------------------------------------------------------------------------
  assign cube_prod  = CUBE_W'(sq_q) * CUBE_W'(quo);
  assign decay_prod = DPROD_W'(held_cur) * DPROD_W'(decay_q);
  assign held_new   = (held_cur > cube_q) ? decay_prod[Q_FRAC +: LEVEL_W] : cube_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CUBE) begin
      sq_q <= SQ_W'(quo) * SQ_W'(quo);
    end
    if (state_q == ST_SHAPE) begin
      cube_q <= cube_prod[CUBE_SHIFT +: LEVEL_W];
    end
  end

  // --------------------------------------------------------------------------
  // Result beat register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= held_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      res_q.band  <= BAND_W'(band_idx_q);
      res_q.level <= held_new;
      res_q.last  <= band_last;
    end
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/sblt_div.sv
// ----------------------------------------------------------------------------
// sblt_div
// Restoring divider for peak * 2^16 / top with peak <= top, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sblt_div
  import sblt_pkg::*;
#(
  parameter int W = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [W-1:0]       dividend_i,
  input  logic [W-1:0]       divisor_i,
  output logic               done_o,
  output logic [LEVEL_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(LEVEL_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(LEVEL_W);

  logic [W:0]         rem_q;
  logic [W-1:0]       div_q;
  logic [LEVEL_W-1:0] quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               run_q;
  logic               first_q;
  logic               done_q;

  logic [W:0] trial;
  logic [W:0] rem_d;
  logic       ge;

  // One quotient bit: the first step takes the peak as is, later ones shift
  always_comb begin
    trial = first_q ? rem_q : {rem_q[W-1:0], 1'b0};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? (trial - {1'b0, div_q}) : trial;
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cnt_q   <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        cnt_q   <= STEPS;
        first_q <= 1'b1;
      end else if (run_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[LEVEL_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/sblt_checker.sv
// ----------------------------------------------------------------------------
// sblt_checker
// Port-level checks of the band level tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sblt_checker
  import sblt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  item_i,
  input logic      res_strobe_o,
  input res_item_t res_o
);

  // A frame end beat starts the output pass
  `SBLT_ASSERT_NEXT(a_frame_busy, clk_i, rst_ni, start && !busy && item_i.frame_end, busy, "frame end beat did not raise busy")

  // Results only come out of the output pass
  `SBLT_ASSERT(a_strobe_in_pass, clk_i, rst_ni, res_strobe_o |-> $past(busy), "result beat outside the output pass")

  // The last band beat closes the pass
  `SBLT_ASSERT(a_last_idle, clk_i, rst_ni, res_strobe_o && res_o.last |-> !busy, "busy still high on last band beat")

  // Band beats follow one another at a fixed spacing, in band order
  `SBLT_ASSERT(a_band_order, clk_i, rst_ni, res_strobe_o && !res_o.last |-> ##23 (res_strobe_o && (res_o.band == 4'($past(res_o.band, 23) + 4'd1))), "band beat missing or out of order")

endmodule

bind spectrum_band_level_tracker_core sblt_checker u_sblt_checker (.*);

`default_nettype wire

FILE: tb/sblt_level_checker.sv
// ----------------------------------------------------------------------------
// sblt_level_checker
// Watches the bin and level beats of the band level tracker and checks them.
// ----------------------------------------------------------------------------
// Folds every accepted bin beat into its own band peak table. On a frame end
// it normalizes, cubes, then decays or replaces the held levels, and queues
// the nine level beats that the core must send. Each level beat is compared
// field by field with the oldest queued one. Counts go out as registered
// values, so the stimulus side sees them without racing this block.
// ----------------------------------------------------------------------------

module sblt_level_checker
  import sblt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DECAY_W-1:0] cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  in_item_t           item_i,
  input  logic               res_strobe_i,
  input  res_item_t          res_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 bins_o,
  output int                 frames_o,
  output int                 levels_o,
  output int                 decays_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_BANDS = 9;
  localparam logic [63:0] Q_ONE   = 64'd65536;

  // Inclusive bin edges of the nine bands
  localparam logic [BIN_W-1:0] EDGE_LO [N_BANDS] = '{
    10'd1, 10'd4, 10'd6, 10'd10, 10'd17, 10'd30, 10'd55, 10'd99, 10'd181
  };
  localparam logic [BIN_W-1:0] EDGE_HI [N_BANDS] = '{
    10'd3, 10'd5, 10'd9, 10'd16, 10'd29, 10'd54, 10'd98, 10'd180, 10'd512
  };

  logic [MAG_W-1:0]   peak_mem [N_BANDS];
  logic [LEVEL_W-1:0] held_mem [N_BANDS];
  logic [DECAY_W-1:0] decay_q16;
  res_item_t          band_level_q [$];

  int fail_cnt = 0;
  int n_bins   = 0;
  int n_frames = 0;
  int n_levels = 0;
  int n_decays = 0;

  // Raise the peak of the band that holds this bin; drop bins outside all bands
  task automatic fold_bin(input in_item_t beat);
    for (int b = 0; b < N_BANDS; b++) begin
      if (beat.bin >= EDGE_LO[b] && beat.bin <= EDGE_HI[b] &&
          beat.magnitude > peak_mem[b]) begin
        peak_mem[b] = beat.magnitude;
      end
    end
  endtask

  // Normalize, cube and hold or decay each band, then queue its level beat
  task automatic emit_frame_levels();
    logic [63:0] top_peak;
    logic [63:0] quot;
    logic [63:0] cube;
    logic [63:0] scaled;
    res_item_t   lvl;
    top_peak = 64'd1;
    for (int b = 0; b < N_BANDS; b++) begin
      if (64'(peak_mem[b]) > top_peak) begin
        top_peak = 64'(peak_mem[b]);
      end
    end
    for (int b = 0; b < N_BANDS; b++) begin
      quot = {8'd0, peak_mem[b], 16'd0} / top_peak;
      if (quot > Q_ONE) begin
        quot = Q_ONE;
      end
      cube = (quot * quot * quot) >> 32;
      if (64'(held_mem[b]) > cube) begin
        scaled      = (64'(held_mem[b]) * 64'(decay_q16)) >> 16;
        held_mem[b] = scaled[LEVEL_W-1:0];
        n_decays++;
      end else begin
        held_mem[b] = cube[LEVEL_W-1:0];
      end
      lvl.band  = BAND_W'(b);
      lvl.level = held_mem[b];
      lvl.last  = (b == N_BANDS - 1);
      band_level_q.push_back(lvl);
      peak_mem[b] = '0;
    end
  endtask

  always @(posedge clk_i) begin
    res_item_t want;
    if (!rst_ni) begin
      // Hold the predictor in its reset state
      for (int b = 0; b < N_BANDS; b++) begin
        peak_mem[b] = '0;
        held_mem[b] = '0;
      end
      decay_q16 = DECAY_RESET;
      band_level_q.delete();
    end else begin
      // Compare a level beat with the oldest expected one
      if (res_strobe_i) begin
        if (band_level_q.size() == 0) begin
          $error("unexpected level beat: band %0d level %0d last %0d",
                 res_i.band, res_i.level, res_i.last);
          fail_cnt++;
        end else begin
          want = band_level_q.pop_front();
          n_levels++;
          if (res_i.band !== want.band) begin
            $error("band: expected %0d, got %0d", want.band, res_i.band);
            fail_cnt++;
          end
          if (res_i.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, res_i.level);
            fail_cnt++;
          end
          if (res_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_i.last);
            fail_cnt++;
          end
        end
      end
      // Track the decay register
      if (cfg_we_i) begin
        decay_q16 = cfg_wdata_i;
      end
      // Advance the predictor on an accepted bin beat
      if (start_i && !busy_i) begin
        n_bins++;
        fold_bin(item_i);
        if (item_i.frame_end) begin
          n_frames++;
          emit_frame_levels();
        end
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= band_level_q.size();
    bins_o     <= n_bins;
    frames_o   <= n_frames;
    levels_o   <= n_levels;
    decays_o   <= n_decays;
  end

endmodule

FILE: tb/spectrum_band_level_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// spectrum_band_level_tracker_core_tb
// Directed and random bin frames through the band level tracker core.
// ----------------------------------------------------------------------------
// Sends a short directed run over the band edges, the ignored bins and the
// all-zero frame, then random frames under several decay settings, with
// random gaps between bin beats. The checker beside the core predicts every
// level beat; this module only drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module spectrum_band_level_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sblt_pkg::*;

  localparam int N_PHASES      = 5;
  localparam int PHASE_BINS    = 78;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_CYCLES  = 40;
  localparam int WDOG_LIMIT    = 2000;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [DECAY_W-1:0] cfg_wdata;
  logic               start;
  logic               busy;
  in_item_t           bin_beat;
  logic               res_strobe;
  res_item_t          level_beat;

  int fail_cnt;
  int pending;
  int n_bins;
  int n_frames;
  int n_levels;
  int n_decays;

  int          sent_bins   = 0;
  int          quiet_count = 0;
  int unsigned n_settings  = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  spectrum_band_level_tracker_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .item_i       (bin_beat),
    .res_strobe_o (res_strobe),
    .res_o        (level_beat)
  );

  sblt_level_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (bin_beat),
    .res_strobe_i (res_strobe),
    .res_i        (level_beat),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .bins_o       (n_bins),
    .frames_o     (n_frames),
    .levels_o     (n_levels),
    .decays_o     (n_decays)
  );

  // End the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || res_strobe) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count == WDOG_LIMIT) begin
        $display("spectrum_band_level_tracker_core_tb: errors");
        $finish;
      end
    end
  end

  function automatic in_item_t make_bin(input int unsigned bin, input logic [MAG_W-1:0] mag,
                                        input logic fe);
    in_item_t beat;
    beat.bin       = BIN_W'(bin);
    beat.magnitude = mag;
    beat.frame_end = fe;
    return beat;
  endfunction

  // No gap half the time or in a burst, else mostly short, a few long
  function automatic int unsigned draw_gap(input bit burst);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (burst || sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a band, then a bin inside it; now and then a bin outside all bands
  function automatic int unsigned draw_bin();
    int unsigned sel;
    int unsigned b;
    sel = $urandom_range(0, 99);
    b   = $urandom_range(0, 8);
    if (sel < 5) return 0;
    if (sel < 15) return $urandom_range(513, 1023);
    return $urandom_range(BAND_LO[b], BAND_HI[b]);
  endfunction

  // Scale a full-width random magnitude down around the frame's scale; now and then all ones, zero or 1 to 3
  function automatic logic [MAG_W-1:0] draw_magnitude(input int unsigned scale);
    logic [63:0] raw;
    int unsigned sel;
    int unsigned shift;
    raw   = {$urandom, $urandom};
    sel   = $urandom_range(0, 99);
    shift = scale + $urandom_range(0, 6);
    if (shift > MAG_W - 1) shift = MAG_W - 1;
    if (sel < 4) return MAG_MAX;
    if (sel < 8) return '0;
    if (sel < 12) return MAG_W'($urandom_range(1, 3));
    return raw[MAG_W-1:0] >> shift;
  endfunction

  // Present one bin beat until it is taken, then idle for the gap
  task automatic send_bin(input in_item_t beat, input int unsigned gap);
    bin_beat <= beat;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    sent_bins++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One frame of random bins closed by a frame end
  task automatic send_frame();
    int unsigned len;
    int unsigned sel;
    int unsigned scale;
    bit          burst;
    logic [MAG_W-1:0] mag;
    sel   = $urandom_range(0, 99);
    len   = (sel < 8) ? 1 : (sel < 90) ? $urandom_range(3, 24) : $urandom_range(30, 70);
    sel   = $urandom_range(0, 99);
    scale = $urandom_range(0, MAG_W - 1);
    burst = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (sel < 6) begin
        mag = '0;
      end else if (sel < 12) begin
        mag = MAG_W'($urandom_range(0, 3));
      end else begin
        mag = draw_magnitude(scale);
      end
      send_bin(make_bin(draw_bin(), mag, i == len - 1), draw_gap(burst));
    end
  endtask

  // Wait for the last level beat and the core going idle, then hold a while
  task automatic settle(input int unsigned hold);
    do @(posedge clk); while (pending != 0 || busy);
    repeat (hold) @(posedge clk);
  endtask

  initial begin
    logic [DECAY_W-1:0] new_decay;
    int                 phase_base;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    bin_beat  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame end on an ignored bin with every peak still zero
    send_bin(make_bin(0, MAG_MAX, 1'b1), draw_gap(1'b0));
    // Low edge of every band at falling magnitudes
    for (int b = 0; b < 9; b++) begin
      send_bin(make_bin(BAND_LO[b], MAG_MAX >> (4 * b), 1'b0), draw_gap(1'b0));
    end
    // Bins past the last band, then a frame end whose own bin ties band 0 at the top
    send_bin(make_bin(513, MAG_MAX, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(1023, MAG_MAX, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(512, MAG_MAX, 1'b1), draw_gap(1'b0));
    // Unit peaks on the high edges; untouched bands decay
    send_bin(make_bin(5, 1, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(9, 1, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(16, 1, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(54, 1, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(98, 1, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(180, 1, 1'b0), draw_gap(1'b0));
    send_bin(make_bin(29, 1, 1'b1), draw_gap(1'b0));
    // Zero magnitude frame end: every band decays
    send_bin(make_bin(3, '0, 1'b1), draw_gap(1'b0));

    // Random frames, one decay setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        start <= 1'b0;
        settle(SETTLE_CYCLES);
        case (p)
          1:       new_decay = '1;
          2:       new_decay = '0;
          default: new_decay = DECAY_W'($urandom_range(0, 65535));
        endcase
        cfg_wdata <= new_decay;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        n_settings++;
      end
      phase_base = sent_bins;
      while (sent_bins - phase_base < PHASE_BINS) begin
        send_frame();
      end
    end

    // Drain and report
    start <= 1'b0;
    settle(DRAIN_CYCLES);
    if (pending != 0) begin
      $error("%0d band levels never arrived", pending);
    end
    $display("summary: %0d bin beats in %0d frames, %0d band levels checked",
             n_bins, n_frames, n_levels);
    $display("summary: %0d held levels decayed over %0d decay settings",
             n_decays, n_settings);
    if (fail_cnt == 0 && pending == 0) begin
      $display("spectrum_band_level_tracker_core_tb: clean");
    end else begin
      $display("spectrum_band_level_tracker_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: spectrum_band_level_tracker_core.f
+incdir+rtl/core
rtl/core/sblt_pkg.sv
rtl/core/sblt_div.sv
rtl/core/spectrum_band_level_tracker_core.sv
rtl/core/sblt_checker.sv
tb/sblt_level_checker.sv
tb/spectrum_band_level_tracker_core_tb.sv
